// ===== rtl/srrm_pkg.sv =====
// Shared types and codes for the segment range read mapper.
package srrm_pkg;
    localparam logic [1:0] KIND_CHUNK   = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_ADD_OK  = 2'd2;
    localparam logic [1:0] KIND_ADD_REJ = 2'd3;
    localparam logic       MODE_ADD     = 1'b0;
    localparam logic       MODE_READ    = 1'b1;
    localparam int         IN_BITS      = 48;
    localparam int         SLOT_BITS    = 4;

    // One transaction as it leaves the front queue
    typedef struct packed {
        logic                mode;
        logic [IN_BITS-1:0]  start_req;
        logic [IN_BITS-1:0]  length;
    } t_req;

    // One result transaction
    typedef struct packed {
        logic [1:0]            kind;
        logic [SLOT_BITS-1:0]  slot;
        logic [IN_BITS-1:0]    src_offset;
        logic [IN_BITS-1:0]    dst_offset;
        logic [IN_BITS-1:0]    chunk_length;
        logic                  needs_zero_fill;
        logic                  full_hit;
        logic                  last;
        logic [31:0]           read_count;
        logic [31:0]           hit_count;
        logic [31:0]           miss_count;
        logic [63:0]           bytes_served;
    } t_res;
endpackage

// ===== rtl/srrm_fifo.sv =====
// Small register queue used between front and back and on the result side.
module srrm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ===== rtl/srrm_engine.sv =====
// Back end: segment table, insert sequencer and read walk sequencer.
module srrm_engine #(
    parameter int TABLE_DEPTH = 16,
    parameter int OFFSET_BITS = 48
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  srrm_pkg::t_req  i_req,
    output logic            o_req_take,
    output logic            o_res_valid,
    output srrm_pkg::t_res  o_res,
    input  logic            i_res_full
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int OB = OFFSET_BITS;
    localparam int W  = srrm_pkg::IN_BITS;
    localparam logic [OB-1:0] OMAX = '1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FIND   = 3'd1;
    localparam logic [2:0] ST_SHIFT  = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_CHUNK  = 3'd4;
    localparam logic [2:0] ST_SUM    = 3'd5;

    logic [OB-1:0]                 r_est [TABLE_DEPTH];
    logic [OB-1:0]                 r_elen [TABLE_DEPTH];
    logic [srrm_pkg::SLOT_BITS-1:0] r_eslot [TABLE_DEPTH];
    logic [CW-1:0]  r_cnt;
    logic [31:0]    r_reads, r_hits, r_miss;
    logic [63:0]    r_served;
    logic [2:0]     r_st;
    logic           r_mode;
    logic [OB-1:0]  r_start, r_len, r_end, r_copied;
    logic [CW-1:0]  r_idx;
    logic [OB-1:0]  r_lo, r_hi, r_s0;
    logic [srrm_pkg::SLOT_BITS-1:0] r_cslot;

    logic [IW-1:0]  w_ix;
    logic [OB-1:0]  w_s, w_l, w_e0, w_in_s, w_in_l;
    logic [OB:0]    w_sum;
    logic           w_in_rng;
    srrm_pkg::t_res w_res;

    assign w_ix     = r_idx[IW-1:0];
    assign w_in_rng = (r_idx < r_cnt);
    assign w_s      = r_est[w_ix];
    assign w_l      = r_elen[w_ix];
    assign w_sum    = {1'b0, w_s} + {1'b0, w_l};
    assign w_e0     = w_sum[OB] ? OMAX : w_sum[OB-1:0];
    assign w_in_s   = OB'(i_req.start_req);
    assign w_in_l   = OB'(i_req.length);

    assign o_req_take = (r_st == ST_IDLE) && i_req_valid;

    // result build
    always_comb begin
        w_res = '0;
        o_res_valid = 1'b0;
        case (r_st)
            ST_CHUNK: begin
                o_res_valid        = 1'b1;
                w_res.kind         = srrm_pkg::KIND_CHUNK;
                w_res.slot         = r_cslot;
                w_res.src_offset   = W'(r_lo - r_s0);
                w_res.dst_offset   = W'(r_lo - r_start);
                w_res.chunk_length = W'(r_hi - r_lo);
            end
            ST_SUM: begin
                o_res_valid = 1'b1;
                w_res.last  = 1'b1;
                if (r_mode == srrm_pkg::MODE_ADD) begin
                    if (r_cnt == CW'(TABLE_DEPTH)) begin
                        w_res.kind = srrm_pkg::KIND_ADD_REJ;
                    end else begin
                        w_res.kind = srrm_pkg::KIND_ADD_OK;
                        w_res.slot = srrm_pkg::SLOT_BITS'(r_cnt);
                    end
                end else begin
                    w_res.kind            = srrm_pkg::KIND_SUMMARY;
                    w_res.chunk_length    = W'(r_copied);
                    w_res.needs_zero_fill = (r_copied < r_len);
                    w_res.full_hit        = (r_len != '0) && (r_copied == r_len);
                    w_res.read_count      = r_reads;
                    w_res.hit_count       = r_hits;
                    w_res.miss_count      = r_miss;
                    w_res.bytes_served    = r_served;
                end
            end
            default: begin
            end
        endcase
    end
    assign o_res = w_res;

    // table storage: insert shifts one entry up per cycle from the top
    always_ff @(posedge i_clk) begin
        if (r_st == ST_SHIFT) begin
            if (r_idx > r_lo[CW-1:0]) begin
                r_est[w_ix]   <= r_est[IW'(r_idx - 1'b1)];
                r_elen[w_ix]  <= r_elen[IW'(r_idx - 1'b1)];
                r_eslot[w_ix] <= r_eslot[IW'(r_idx - 1'b1)];
            end else begin
                r_est[w_ix]   <= r_start;
                r_elen[w_ix]  <= r_len;
                r_eslot[w_ix] <= srrm_pkg::SLOT_BITS'(r_cnt);
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_cnt    <= '0;
            r_reads  <= '0;
            r_hits   <= '0;
            r_miss   <= '0;
            r_served <= '0;
        end else begin
            case (r_st)
                ST_IDLE: begin
                    if (i_req_valid) begin
                        r_mode   <= i_req.mode;
                        r_start  <= w_in_s;
                        r_len    <= w_in_l;
                        r_end    <= (({1'b0, w_in_s} + {1'b0, w_in_l}) > {1'b0, OMAX})
                                    ? OMAX : w_in_s + w_in_l;
                        r_copied <= '0;
                        r_idx    <= '0;
                        r_lo     <= '0;
                        if (i_req.mode == srrm_pkg::MODE_ADD) begin
                            r_st <= (r_cnt == CW'(TABLE_DEPTH)) ? ST_SUM : ST_FIND;
                        end else begin
                            r_reads <= r_reads + 1'b1;
                            r_st    <= (w_in_l == '0) ? ST_SUM : ST_FIND;
                        end
                    end
                end
                ST_FIND: begin
                    // count entries with start <= key, one per cycle
                    if (w_in_rng && w_s <= r_start) begin
                        r_idx <= r_idx + 1'b1;
                    end else if (r_mode == srrm_pkg::MODE_ADD) begin
                        r_lo  <= OB'(r_idx);
                        r_idx <= r_cnt;
                        r_st  <= ST_SHIFT;
                    end else begin
                        if (r_idx != '0) begin
                            r_idx <= r_idx - 1'b1;
                        end
                        r_st <= ST_WALK;
                    end
                end
                ST_SHIFT: begin
                    if (r_idx > r_lo[CW-1:0]) begin
                        r_idx <= r_idx - 1'b1;
                    end else begin
                        r_st <= ST_SUM;
                    end
                end
                ST_WALK: begin
                    if (w_in_rng && w_s < r_end) begin
                        r_idx <= r_idx + 1'b1;
                        if (w_e0 > r_start) begin
                            r_lo    <= (w_s > r_start) ? w_s : r_start;
                            r_hi    <= (w_e0 < r_end) ? w_e0 : r_end;
                            r_s0    <= w_s;
                            r_cslot <= r_eslot[w_ix];
                            if (((w_e0 < r_end) ? w_e0 : r_end) >
                                ((w_s > r_start) ? w_s : r_start)) begin
                                r_st <= ST_CHUNK;
                            end
                        end
                    end else begin
                        if (r_copied == r_len) begin
                            r_hits <= r_hits + 1'b1;
                        end else begin
                            r_miss <= r_miss + 1'b1;
                        end
                        r_served <= r_served + 64'(r_copied);
                        r_st     <= ST_SUM;
                    end
                end
                ST_CHUNK: begin
                    if (!i_res_full) begin
                        r_copied <= r_copied + (r_hi - r_lo);
                        r_st     <= ST_WALK;
                    end
                end
                ST_SUM: begin
                    if (!i_res_full) begin
                        if (r_mode == srrm_pkg::MODE_ADD && r_cnt != CW'(TABLE_DEPTH)) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/segment_range_read_mapper.sv =====
// Segment range read mapper: an input queue feeds a table sequencer that writes to a
// result queue. An add is taken, then searched for its position at one entry per cycle,
// shifted into the table at one entry per cycle and answered with one result; a rejected
// add or a zero-length read goes straight from being taken to its result. A read is taken,
// searched for its position, then the walk sequencer visits the table entries one at a time,
// giving one chunk result per overlap, and a summary result ends it. A full result queue
// stalls the sequencer. Input and result queues let both sides stall freely.
module segment_range_read_mapper #(
    parameter int TABLE_DEPTH = 16,
    parameter int OFFSET_BITS = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_mode,
    input  logic [47:0] i_start_req,
    input  logic [47:0] i_length,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_slot,
    output logic [47:0] o_src_offset,
    output logic [47:0] o_dst_offset,
    output logic [47:0] o_chunk_length,
    output logic        o_needs_zero_fill,
    output logic        o_full_hit,
    output logic        o_last,
    output logic [31:0] o_read_count,
    output logic [31:0] o_hit_count,
    output logic [31:0] o_miss_count,
    output logic [63:0] o_bytes_served
);
    localparam int RW = $bits(srrm_pkg::t_req);
    localparam int SW = $bits(srrm_pkg::t_res);

    srrm_pkg::t_req w_in, w_req;
    srrm_pkg::t_res w_res, w_out;
    logic           w_req_empty, w_take, w_res_valid, w_res_full;

    assign w_in.mode      = i_mode;
    assign w_in.start_req = i_start_req;
    assign w_in.length    = i_length;

    // front queue
    srrm_fifo #(.WIDTH(RW), .DEPTH(2)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(w_in), .o_full(full),
        .i_pop(w_take), .o_empty(w_req_empty), .o_data(w_req)
    );

    srrm_engine #(.TABLE_DEPTH(TABLE_DEPTH), .OFFSET_BITS(OFFSET_BITS)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(!w_req_empty), .i_req(w_req), .o_req_take(w_take),
        .o_res_valid(w_res_valid), .o_res(w_res), .i_res_full(w_res_full)
    );

    // result queue
    srrm_fifo #(.WIDTH(SW), .DEPTH(2)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_res_valid), .i_data(w_res), .o_full(w_res_full),
        .i_pop(pop), .o_empty(empty), .o_data(w_out)
    );

    assign o_kind            = w_out.kind;
    assign o_slot            = w_out.slot;
    assign o_src_offset      = w_out.src_offset;
    assign o_dst_offset      = w_out.dst_offset;
    assign o_chunk_length    = w_out.chunk_length;
    assign o_needs_zero_fill = w_out.needs_zero_fill;
    assign o_full_hit        = w_out.full_hit;
    assign o_last            = w_out.last;
    assign o_read_count      = w_out.read_count;
    assign o_hit_count       = w_out.hit_count;
    assign o_miss_count      = w_out.miss_count;
    assign o_bytes_served    = w_out.bytes_served;
endmodule

// ===== bench/tb_segment_range_read_mapper.sv =====
// Self-checking testbench for the segment range read mapper: random and directed adds and reads.
module tb_segment_range_read_mapper;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam logic [47:0] OFS_MAX = 48'hFFFF_FFFF_FFFF;
    localparam longint CYCLE_LIMIT = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_mode = srrm_pkg::MODE_ADD;
    logic [47:0] i_start_req = '0;
    logic [47:0] i_length = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_kind;
    logic [3:0]  o_slot;
    logic [47:0] o_src_offset;
    logic [47:0] o_dst_offset;
    logic [47:0] o_chunk_length;
    logic        o_needs_zero_fill;
    logic        o_full_hit;
    logic        o_last;
    logic [31:0] o_read_count;
    logic [31:0] o_hit_count;
    logic [31:0] o_miss_count;
    logic [63:0] o_bytes_served;

    segment_range_read_mapper DUT (.*);

    // Predictor state: segment table and read statistics
    logic [47:0] seg_start [DEPTH];
    logic [47:0] seg_len [DEPTH];
    logic [3:0]  seg_slot [DEPTH];
    int          seg_count;
    logic [31:0] reads_n, hits_n, misses_n;
    logic [63:0] served_n;

    srrm_pkg::t_req pending_reqs[$];
    srrm_pkg::t_res expected_results[$];
    int   send_idle_pct, recv_idle_pct;
    int   hold_cycles;
    bit   failed;
    bit   in_taken;
    longint cycle_n;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [47:0] clip_end(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? OFS_MAX : s[47:0];
    endfunction

    function automatic int first_after(logic [47:0] key);
        int i;
        i = 0;
        while (i < seg_count && seg_start[i] <= key) i++;
        return i;
    endfunction

    function automatic srrm_pkg::t_res blank_result(logic [1:0] kind);
        srrm_pkg::t_res r;
        r = '0;
        r.kind = kind;
        return r;
    endfunction

    function automatic void queue_req(srrm_pkg::t_req q);
        pending_reqs = {pending_reqs, q};
    endfunction

    function automatic void expect_res(srrm_pkg::t_res r);
        expected_results = {expected_results, r};
    endfunction

    // Work out the results one transaction causes and advance the predictor
    task automatic map_request(srrm_pkg::t_req q);
        srrm_pkg::t_res r, c;
        int pos, i;
        logic [47:0] rd_end, s0, e0, lo, hi, copied;
        if (q.mode == srrm_pkg::MODE_ADD) begin
            if (seg_count >= DEPTH) begin
                r = blank_result(srrm_pkg::KIND_ADD_REJ);
                r.last = 1'b1;
                expect_res(r);
                return;
            end
            pos = first_after(q.start_req);
            for (i = seg_count; i > pos; i--) begin
                seg_start[i] = seg_start[i-1];
                seg_len[i]   = seg_len[i-1];
                seg_slot[i]  = seg_slot[i-1];
            end
            seg_start[pos] = q.start_req;
            seg_len[pos]   = q.length;
            seg_slot[pos]  = 4'(seg_count);
            r = blank_result(srrm_pkg::KIND_ADD_OK);
            r.slot = 4'(seg_count);
            r.last = 1'b1;
            expect_res(r);
            seg_count++;
            return;
        end
        reads_n++;
        r = blank_result(srrm_pkg::KIND_SUMMARY);
        r.last = 1'b1;
        if (q.length != 0) begin
            rd_end = clip_end(q.start_req, q.length);
            copied = '0;
            i = first_after(q.start_req);
            if (i > 0) i--;
            for (; i < seg_count && seg_start[i] < rd_end; i++) begin
                s0 = seg_start[i];
                e0 = clip_end(s0, seg_len[i]);
                if (e0 <= q.start_req) continue;
                lo = (s0 > q.start_req) ? s0 : q.start_req;
                hi = (e0 < rd_end) ? e0 : rd_end;
                if (hi <= lo) continue;
                c = blank_result(srrm_pkg::KIND_CHUNK);
                c.slot = seg_slot[i];
                c.src_offset = lo - s0;
                c.dst_offset = lo - q.start_req;
                c.chunk_length = hi - lo;
                expect_res(c);
                copied += hi - lo;
            end
            if (copied == q.length) hits_n++;
            else misses_n++;
            served_n += 64'(copied);
            r.chunk_length = copied;
            r.needs_zero_fill = copied < q.length;
            r.full_hit = copied == q.length;
        end
        r.read_count = reads_n;
        r.hit_count = hits_n;
        r.miss_count = misses_n;
        r.bytes_served = served_n;
        expect_res(r);
    endtask

    // Acceptance of the offered transaction, seen at the rising edge
    always @(posedge i_clk) begin
        in_taken = i_rst_n && push && !full;
    end

    // Driver: offer queued transactions at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (in_taken) begin
                map_request(pending_reqs[0]);
                void'(pending_reqs.pop_front());
            end
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                push        <= 1'b1;
                i_mode      <= pending_reqs[0].mode;
                i_start_req <= pending_reqs[0].start_req;
                i_length    <= pending_reqs[0].length;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: random pop, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end else begin
            pop <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each popped result with the oldest expectation
    always @(posedge i_clk) begin
        srrm_pkg::t_res got, want;
        cycle_n <= cycle_n + 1;
        if (i_rst_n && pop && !empty) begin
            got = '{o_kind, o_slot, o_src_offset, o_dst_offset, o_chunk_length,
                    o_needs_zero_fill, o_full_hit, o_last, o_read_count,
                    o_hit_count, o_miss_count, o_bytes_served};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result exp none got %h", $time, got);
                failed = 1'b1;
            end else begin
                want = expected_results.pop_front();
                if (got.kind != want.kind)
                    $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
                if (got.slot != want.slot)
                    $display("%0t: slot exp %0d got %0d", $time, want.slot, got.slot);
                if (got.src_offset != want.src_offset)
                    $display("%0t: src_offset exp %h got %h", $time, want.src_offset,
                             got.src_offset);
                if (got.dst_offset != want.dst_offset)
                    $display("%0t: dst_offset exp %h got %h", $time, want.dst_offset,
                             got.dst_offset);
                if (got.chunk_length != want.chunk_length)
                    $display("%0t: chunk_length exp %h got %h", $time, want.chunk_length,
                             got.chunk_length);
                if (got.needs_zero_fill != want.needs_zero_fill)
                    $display("%0t: needs_zero_fill exp %b got %b", $time,
                             want.needs_zero_fill, got.needs_zero_fill);
                if (got.full_hit != want.full_hit)
                    $display("%0t: full_hit exp %b got %b", $time, want.full_hit,
                             got.full_hit);
                if (got.last != want.last)
                    $display("%0t: last exp %b got %b", $time, want.last, got.last);
                if (got.read_count != want.read_count)
                    $display("%0t: read_count exp %0d got %0d", $time, want.read_count,
                             got.read_count);
                if (got.hit_count != want.hit_count)
                    $display("%0t: hit_count exp %0d got %0d", $time, want.hit_count,
                             got.hit_count);
                if (got.miss_count != want.miss_count)
                    $display("%0t: miss_count exp %0d got %0d", $time, want.miss_count,
                             got.miss_count);
                if (got.bytes_served != want.bytes_served)
                    $display("%0t: bytes_served exp %h got %h", $time, want.bytes_served,
                             got.bytes_served);
                if (got != want) failed = 1'b1;
            end
        end
        if (cycle_n > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic srrm_pkg::t_req make_req(logic mode, logic [47:0] s, logic [47:0] l);
        srrm_pkg::t_req q;
        q.mode = mode;
        q.start_req = s;
        q.length = l;
        return q;
    endfunction

    // Small segments in a narrow window mixed with many reads and some random requests
    task automatic queue_random_phase(int n_items);
        logic [47:0] base, s, l;
        int k;
        base = ($urandom_range(9) == 0) ? OFS_MAX - 48'd3000 : rand48() >> $urandom_range(47);
        for (k = 0; k < n_items; k++) begin
            case ($urandom_range(9))
                0, 1: queue_req(make_req(srrm_pkg::MODE_ADD,
                          base + 48'($urandom_range(2000)), 48'($urandom_range(400))));
                2: queue_req(make_req(1'($urandom_range(1)), rand48(), rand48()));
                default: begin
                    s = base + 48'($urandom_range(2200));
                    l = ($urandom_range(15) == 0) ? 48'd0 : 48'($urandom_range(900));
                    if ($urandom_range(19) == 0) l = rand48();
                    queue_req(make_req(srrm_pkg::MODE_READ, s - 48'd100, l));
                end
            endcase
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_results.size() > 0) @(posedge i_clk);
    endtask

    // Stimulus and end of run
    initial begin
        int p;
        failed = 1'b0;
        cycle_n = 0;
        hold_cycles = 0;
        seg_count = 0;
        reads_n = '0; hits_n = '0; misses_n = '0; served_n = '0;
        send_idle_pct = 31;
        recv_idle_pct = 82;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty reads, zero-length read, equal starts, zero-length segment
        queue_req(make_req(srrm_pkg::MODE_READ, 48'd0, 48'd10));
        queue_req(make_req(srrm_pkg::MODE_READ, 48'd5, 48'd0));
        queue_req(make_req(srrm_pkg::MODE_ADD, 48'd100, 48'd50));
        queue_req(make_req(srrm_pkg::MODE_ADD, 48'd100, 48'd20));
        queue_req(make_req(srrm_pkg::MODE_ADD, 48'd0, 48'd0));
        queue_req(make_req(srrm_pkg::MODE_ADD, 48'd200, 48'd100));
        queue_req(make_req(srrm_pkg::MODE_READ, 48'd100, 48'd50));
        queue_req(make_req(srrm_pkg::MODE_READ, 48'd50, 48'd300));
        queue_req(make_req(srrm_pkg::MODE_READ, 48'd210, 48'd20));
        queue_req(make_req(srrm_pkg::MODE_READ, 48'd150, 48'd50));
        queue_req(make_req(srrm_pkg::MODE_ADD, OFS_MAX - 48'd10, OFS_MAX));
        queue_req(make_req(srrm_pkg::MODE_READ, OFS_MAX - 48'd20, OFS_MAX));
        queue_req(make_req(srrm_pkg::MODE_READ, OFS_MAX, OFS_MAX));
        queue_req(make_req(srrm_pkg::MODE_READ, 48'd0, OFS_MAX));
        for (p = 0; p < 12; p++)
            queue_req(make_req(srrm_pkg::MODE_ADD, 48'(p * 7), 48'd5));
        queue_req(make_req(srrm_pkg::MODE_READ, 48'd0, 48'd400));
        // Receiver holds off while the sender keeps pushing
        hold_cycles = 600;
        drain();

        // Random phases, each after reset state of a fresh table is impossible,
        // so the table fills up and later adds exercise rejection
        queue_random_phase(150);
        drain();
        send_idle_pct = 82;
        recv_idle_pct = 31;
        queue_random_phase(150);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_phase(130);
        drain();
        repeat (200) @(posedge i_clk);
        if (!failed && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/srrm_pkg.sv
rtl/srrm_fifo.sv
rtl/srrm_engine.sv
rtl/segment_range_read_mapper.sv
bench/tb_segment_range_read_mapper.sv
